// File: sv/rc_pulse_light_pattern_controller_defines.svh
// ---------------------------------------------------------------------------
// RC pulse light pattern controller - assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef RC_PULSE_LIGHT_PATTERN_CONTROLLER_DEFINES_SVH
`define RC_PULSE_LIGHT_PATTERN_CONTROLLER_DEFINES_SVH

// same-cycle implication, held off during reset
`define RCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rcplpc_pkg.sv
// ---------------------------------------------------------------------------
// rcplpc_pkg
// Shared widths, constants and codes of the RC pulse light controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcplpc_pkg;

    localparam int WIDTH_W      = 16;
    localparam int SAMPLE_COUNT = 5;

    // ring index and running sum widths
    localparam int SLOT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int SUM_W  = WIDTH_W + $clog2(SAMPLE_COUNT);

    // floor(sum / SAMPLE_COUNT) as (sum * RECIP) >> DIV_SHIFT, exact over SUM_W bits
    localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    typedef logic [WIDTH_W-1:0] t_width;

    // mode codes, shown on the animation output
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_TAIL  = 2'd1;
    localparam logic [1:0] MODE_HEAD  = 2'd2;
    localparam logic [1:0] MODE_FLASH = 2'd3;

    // phase durations in ticks
    localparam int TIMER_W = 10;
    localparam logic [TIMER_W-1:0] DUR_LONG_TAIL = TIMER_W'(925);
    localparam logic [TIMER_W-1:0] DUR_LONG_BOTH = TIMER_W'(425);
    localparam logic [TIMER_W-1:0] DUR_SHORT     = TIMER_W'(75);
    localparam logic [TIMER_W-1:0] DUR_NONE      = '0;

    // register reset values
    localparam t_width     RST_THRESHOLD_HIGH = 16'd1700;
    localparam t_width     RST_THRESHOLD_LOW  = 16'd1300;
    localparam logic [7:0] RST_SAMPLE_PERIOD  = 8'd50;
    localparam t_width     RST_DUTY_BRIGHT    = 16'd1000;
    localparam t_width     RST_DUTY_DIM       = 16'd750;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_THRESHOLD_HIGH = 3'd0;
    localparam logic [2:0] REG_THRESHOLD_LOW  = 3'd1;
    localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd2;
    localparam logic [2:0] REG_DUTY_BRIGHT    = 3'd3;
    localparam logic [2:0] REG_DUTY_DIM       = 3'd4;

endpackage

`default_nettype wire

// File: sv/rc_pulse_light_pattern_controller.sv
// ---------------------------------------------------------------------------
// rc_pulse_light_pattern_controller
// Averages RC pulse widths and drives head and tail light duty patterns.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one word per 1 ms tick, carrying
//   i_pulse_valid and i_pulse_width. Output channel (o_out_valid /
//   i_out_stall): exactly one result word per input word, in order.
//   Path: a word that is accepted lands in the input register; its result
//   is loaded into the result register once that register is free, which
//   raises o_out_valid. Throughput: one word per clock while the result
//   side does not stall. The whole tick update (running sum, divide by the
//   sample count through a constant multiply, threshold compare, phase
//   timer) is one pass of logic between the two registers.
//   Stall: when the result register is full and i_out_stall is high, the
//   result holds and the input register holds; o_in_stall rises only once
//   the input register is also full, so one word is absorbed while stalled.
//   Reset (i_rst_n low, synchronous): both channels empty, config registers
//   back to their defaults, sample ring and sum zero, mode off with rising
//   polarity expected; the first word after reset takes a sample step.
//   Config: APB-style, pready tied high, registers at byte offsets 4*i.
//   Write only while no word is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_light_pattern_controller
    import rcplpc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input words
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic         i_pulse_valid,
    input  wire logic [15:0]  i_pulse_width,
    // result words
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [15:0]       o_head_duty,
    output logic [15:0]       o_tail_duty,
    output logic [1:0]        o_animation,
    output logic [15:0]       o_smoothed_width,
    // config port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    t_width     r_thr_high;
    t_width     r_thr_low;
    logic [7:0] r_period;
    t_width     r_duty_bright;
    t_width     r_duty_dim;

    logic       s_cfg_wr;
    logic [2:0] s_cfg_idx;

    assign pready    = 1'b1;
    assign s_cfg_idx = paddr[4:2];
    assign s_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_high    <= RST_THRESHOLD_HIGH;
            r_thr_low     <= RST_THRESHOLD_LOW;
            r_period      <= RST_SAMPLE_PERIOD;
            r_duty_bright <= RST_DUTY_BRIGHT;
            r_duty_dim    <= RST_DUTY_DIM;
        end else if (s_cfg_wr) begin
            unique case (s_cfg_idx)
                REG_THRESHOLD_HIGH: r_thr_high    <= pwdata[15:0];
                REG_THRESHOLD_LOW:  r_thr_low     <= pwdata[15:0];
                REG_SAMPLE_PERIOD:  r_period      <= pwdata[7:0];
                REG_DUTY_BRIGHT:    r_duty_bright <= pwdata[15:0];
                REG_DUTY_DIM:       r_duty_dim    <= pwdata[15:0];
                default: ;  // unmapped offsets ignore writes
            endcase
        end
    end

    always_comb begin
        unique case (s_cfg_idx)
            REG_THRESHOLD_HIGH: prdata = {16'd0, r_thr_high};
            REG_THRESHOLD_LOW:  prdata = {16'd0, r_thr_low};
            REG_SAMPLE_PERIOD:  prdata = {24'd0, r_period};
            REG_DUTY_BRIGHT:    prdata = {16'd0, r_duty_bright};
            REG_DUTY_DIM:       prdata = {16'd0, r_duty_dim};
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: input register -> result register
    // ---------------------------------------------------------------
    logic   r_in_valid;
    logic   r_pulse_valid;
    t_width r_pulse_width;
    logic   r_out_valid;

    logic s_out_ready;  // result register can load this cycle
    logic s_in_ready;   // input register can load this cycle
    logic s_fire;       // buffered word is processed this cycle

    assign s_out_ready = !r_out_valid || !i_out_stall;
    assign s_fire      = r_in_valid && s_out_ready;
    assign s_in_ready  = !r_in_valid || s_out_ready;
    assign o_in_stall  = !s_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s_out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge i_clk) begin
        if (s_in_ready && i_in_valid) begin
            r_pulse_valid <= i_pulse_valid;
            r_pulse_width <= i_pulse_width;
        end
    end

    // ---------------------------------------------------------------
    // Tick state
    // ---------------------------------------------------------------
    t_width              r_ring [SAMPLE_COUNT];
    logic [SUM_W-1:0]    r_sum;        // running sum of the ring
    logic [SLOT_W-1:0]   r_slot;
    t_width              r_held_width;
    logic                r_held_fresh;
    logic [7:0]          r_step_cnt;
    logic [1:0]          r_mode;
    logic                r_off_latch;
    logic                r_expect_rise;
    logic [1:0]          r_pattern;    // 0 none/off, else pattern of that mode
    logic [1:0]          r_phase;
    logic [TIMER_W-1:0]  r_timer;
    t_width              r_last_avg;

    t_width              n_ring [SAMPLE_COUNT];
    logic [SUM_W-1:0]    n_sum;
    logic [SLOT_W-1:0]   n_slot;
    t_width              n_held_width;
    logic                n_held_fresh;
    logic [7:0]          n_step_cnt;
    logic [1:0]          n_mode;
    logic                n_off_latch;
    logic                n_expect_rise;
    logic [1:0]          n_pattern;
    logic [1:0]          n_phase;
    logic [TIMER_W-1:0]  n_timer;
    t_width              n_last_avg;
    t_width              n_head;
    t_width              n_tail;

    // step arithmetic
    t_width              s_sample;
    logic [PROD_W-1:0]   s_prod;
    t_width              s_avg;
    logic [8:0]          s_cnt_inc;
    logic [7:0]          s_period;
    logic [TIMER_W-1:0]  s_dur;
    logic                s_four_phase;
    logic [TIMER_W:0]    s_timer_inc;
    logic [1:0]          s_phase_inc;

    always_comb begin
        n_ring        = r_ring;
        n_sum         = r_sum;
        n_slot        = r_slot;
        n_held_width  = r_held_width;
        n_held_fresh  = r_held_fresh;
        n_step_cnt    = r_step_cnt;
        n_mode        = r_mode;
        n_off_latch   = r_off_latch;
        n_expect_rise = r_expect_rise;
        n_pattern     = r_pattern;
        n_phase       = r_phase;
        n_timer       = r_timer;
        n_last_avg    = r_last_avg;
        n_head        = '0;
        n_tail        = '0;
        s_dur         = DUR_NONE;
        s_four_phase  = 1'b0;

        // fresh pulse is latched first so a step in the same tick sees it
        if (r_pulse_valid) begin
            n_held_width = r_pulse_width;
            n_held_fresh = 1'b1;
        end

        // sample step: replace oldest entry, update sum, divide by count
        s_sample = n_held_fresh ? n_held_width : '0;
        n_sum    = r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(s_sample);
        s_prod   = PROD_W'(n_sum) * PROD_W'(RECIP);
        s_avg    = s_prod[DIV_SHIFT +: WIDTH_W];

        if (r_step_cnt == 8'd0) begin
            n_ring[r_slot] = s_sample;
            n_held_fresh   = 1'b0;
            n_last_avg     = s_avg;
            n_slot         = (r_slot == SLOT_W'(SAMPLE_COUNT - 1)) ? '0 : r_slot + 1'b1;

            if (s_avg == '0 && !r_off_latch) begin
                n_pattern   = MODE_OFF;
                n_phase     = '0;
                n_timer     = '0;
                n_mode      = MODE_OFF;
                n_off_latch = 1'b1;
            end else if ((s_avg > r_thr_high && r_expect_rise) ||
                         (s_avg < r_thr_low && !r_expect_rise)) begin
                n_mode        = r_mode + 2'd1;
                n_pattern     = r_mode + 2'd1;
                n_phase       = '0;
                n_timer       = '0;
                n_expect_rise = !r_expect_rise;
                n_off_latch   = 1'b0;
            end
        end else begin
            n_sum = r_sum;
        end

        // step counter, period zero acts as one
        s_period  = (r_period == 8'd0) ? 8'd1 : r_period;
        s_cnt_inc = {1'b0, r_step_cnt} + 9'd1;
        n_step_cnt = (s_cnt_inc >= {1'b0, s_period}) ? 8'd0 : s_cnt_inc[7:0];

        // light levels of the current phase
        case (n_pattern)
            MODE_TAIL, MODE_HEAD: begin
                n_head = (n_pattern == MODE_HEAD) ? r_duty_bright : '0;
                if (!n_phase[0]) begin
                    n_tail = r_duty_dim;
                    s_dur  = DUR_LONG_TAIL;
                end else begin
                    n_tail = r_duty_bright;
                    s_dur  = DUR_SHORT;
                end
            end
            MODE_FLASH: begin
                s_four_phase = 1'b1;
                if (!n_phase[0]) begin
                    n_head = r_duty_bright;
                    n_tail = r_duty_dim;
                    s_dur  = DUR_LONG_BOTH;
                end else if (!n_phase[1]) begin
                    n_head = r_duty_dim;
                    n_tail = r_duty_dim;
                    s_dur  = DUR_SHORT;
                end else begin
                    n_head = r_duty_dim;
                    n_tail = r_duty_bright;
                    s_dur  = DUR_SHORT;
                end
            end
            default: ;
        endcase

        // phase timer
        s_timer_inc = {1'b0, n_timer} + 1'b1;
        s_phase_inc = s_four_phase ? n_phase + 2'd1 : {1'b0, ~n_phase[0]};
        if (s_dur != DUR_NONE) begin
            if (s_timer_inc >= {1'b0, s_dur}) begin
                n_timer = '0;
                n_phase = s_phase_inc;
            end else begin
                n_timer = s_timer_inc[TIMER_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                r_ring[i] <= '0;
            end
            r_sum         <= '0;
            r_slot        <= '0;
            r_held_width  <= '0;
            r_held_fresh  <= 1'b0;
            r_step_cnt    <= '0;
            r_mode        <= MODE_OFF;
            r_off_latch   <= 1'b0;
            r_expect_rise <= 1'b1;
            r_pattern     <= MODE_OFF;
            r_phase       <= '0;
            r_timer       <= '0;
            r_last_avg    <= '0;
        end else if (s_fire) begin
            r_ring        <= n_ring;
            r_sum         <= n_sum;
            r_slot        <= n_slot;
            r_held_width  <= n_held_width;
            r_held_fresh  <= n_held_fresh;
            r_step_cnt    <= n_step_cnt;
            r_mode        <= n_mode;
            r_off_latch   <= n_off_latch;
            r_expect_rise <= n_expect_rise;
            r_pattern     <= n_pattern;
            r_phase       <= n_phase;
            r_timer       <= n_timer;
            r_last_avg    <= n_last_avg;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            o_head_duty      <= n_head;
            o_tail_duty      <= n_tail;
            o_animation      <= n_mode;
            o_smoothed_width <= n_last_avg;
        end
    end

endmodule

`default_nettype wire

// File: sv/rcplpc_checker.sv
// ---------------------------------------------------------------------------
// rcplpc_checker
// Port-level checks of the RC pulse light pattern controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rc_pulse_light_pattern_controller_defines.svh"

module rcplpc_checker
    import rcplpc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_head_duty,
    input wire logic [15:0] o_tail_duty,
    input wire logic [1:0]  o_animation,
    input wire logic [15:0] o_smoothed_width
);

    // off mode drives both lights dark
    `RCP_ASSERT_NOW(a_off_dark, i_clk, i_rst_n, o_out_valid && o_animation == MODE_OFF, o_head_duty == 16'd0 && o_tail_duty == 16'd0, "off mode with lit output")

    // tail-only mode keeps the headlight dark
    `RCP_ASSERT_NOW(a_tail_only, i_clk, i_rst_n, o_out_valid && o_animation == MODE_TAIL, o_head_duty == 16'd0, "headlight lit in tail mode")

    // input back-pressure only comes from a held result
    `RCP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without output stall")

    // stalled result word holds
    `RCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_head_duty) && $stable(o_tail_duty) && $stable(o_animation) && $stable(o_smoothed_width), "stalled result changed")

endmodule

bind rc_pulse_light_pattern_controller rcplpc_checker u_rcplpc_checker (.*);

`default_nettype wire

// File: tb/sv/rc_pulse_light_pattern_controller_tb.sv
// ---------------------------------------------------------------------------
// rc_pulse_light_pattern_controller_tb
// Self-checking bench for the RC pulse light pattern controller. Input words
// are sent in random bursts while the result side stalls on its own pattern.
// Each accepted input word is run through an in-bench model of the averager,
// the hysteresis mode logic and the head/tail duty patterns. Every result
// word is compared field by field against that model, in order. Registers
// are written over the APB port between traffic phases and read back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_pulse_light_pattern_controller_tb;
    import rcplpc_pkg::*;

    localparam int RANDOM_WORDS    = 240;
    localparam int PHASE_WORDS     = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PATTERN_HOLD    = 1010;  // long enough to wrap the flash pattern once
    localparam int MAX_REPORTS     = 10;

    // one expected result word
    typedef struct packed {
        logic [15:0] head;
        logic [15:0] tail;
        logic [1:0]  anim;
        logic [15:0] avg;
    } light_word_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY4} stall_style_t;
    typedef enum int {SEG_STEER, SEG_SILENT, SEG_MID, SEG_NOISE} segment_t;

    // DUT signals, all inputs known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_pulse_valid = 1'b0;
    logic [15:0] i_pulse_width = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [15:0] o_head_duty;
    logic [15:0] o_tail_duty;
    logic [1:0]  o_animation;
    logic [15:0] o_smoothed_width;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // model copy of the registers
    t_width     thr_high_q;
    t_width     thr_low_q;
    logic [7:0] period_q;
    t_width     bright_q;
    t_width     dim_q;

    // model copy of the block state
    t_width     ring_q [SAMPLE_COUNT];
    int         slot_q;
    t_width     held_q;
    logic       held_new_q;
    logic [7:0] step_cnt_q;
    logic [1:0] mode_q;
    logic [1:0] pattern_q;
    logic [1:0] phase_q;
    int         phase_ticks_q;
    logic       off_latch_q;
    logic       want_rise_q;
    t_width     avg_q;

    // result words still owed by the block, oldest first
    light_word_t expected_lights [$];

    // bookkeeping
    int         mismatches     = 0;
    int         words_sent     = 0;
    int         words_checked  = 0;
    int         steps_taken    = 0;
    int         cfg_writes     = 0;
    int         stalled_cycles = 0;
    logic [3:0] modes_seen     = '0;

    // sender and receiver pacing
    int           burst_left   = 0;
    bit           sender_eager = 1'b0;
    bit           hold_off_req = 1'b0;
    int           hold_left    = 0;
    stall_style_t stall_style  = STALL_NONE;
    int           style_left   = 0;

    rc_pulse_light_pattern_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pulse_valid    (i_pulse_valid),
        .i_pulse_width    (i_pulse_width),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_head_duty      (o_head_duty),
        .o_tail_duty      (o_tail_duty),
        .o_animation      (o_animation),
        .o_smoothed_width (o_smoothed_width),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    function automatic t_width clamp_width(int v);
        if (v < 0) return '0;
        if (v > 65535) return 16'hFFFF;
        return t_width'(v);
    endfunction

    // One 1 ms tick of the light controller: latch the pulse, take a sample
    // step if due, form head/tail from the current phase, then age the phase.
    function automatic light_word_t light_tick(logic pv, t_width pw);
        light_word_t w;
        logic [7:0]  span;
        logic [31:0] sum;
        logic [31:0] mean;
        int          dur;
        int          nph;
        int          k;
        w    = '0;
        dur  = 0;
        nph  = 1;
        span = (period_q == 8'd0) ? 8'd1 : period_q;  // period zero acts as one
        if (pv) begin
            held_q     = pw;    // only the latest pulse between steps survives
            held_new_q = 1'b1;
        end
        if (step_cnt_q == 8'd0) begin
            ring_q[slot_q] = held_new_q ? held_q : '0;
            held_new_q     = 1'b0;
            sum = '0;
            for (k = 0; k < SAMPLE_COUNT; k++) begin
                sum += ring_q[k];
            end
            mean   = sum / SAMPLE_COUNT;
            avg_q  = mean[15:0];
            slot_q = (slot_q + 1) % SAMPLE_COUNT;
            steps_taken++;
            if (mean == 0 && !off_latch_q) begin
                // zero average: go dark once, then stay latched
                mode_q        = MODE_OFF;
                pattern_q     = MODE_OFF;
                phase_q       = '0;
                phase_ticks_q = 0;
                off_latch_q   = 1'b1;
            end else if ((mean > thr_high_q && want_rise_q) ||
                         (mean < thr_low_q && !want_rise_q)) begin
                // gated crossing; wrapping to off leaves the latch clear
                mode_q        = mode_q + 2'd1;
                pattern_q     = mode_q;
                phase_q       = '0;
                phase_ticks_q = 0;
                want_rise_q   = !want_rise_q;
                off_latch_q   = 1'b0;
            end
            modes_seen[mode_q] = 1'b1;
        end
        step_cnt_q = step_cnt_q + 8'd1;
        if (step_cnt_q >= span) step_cnt_q = '0;

        case (pattern_q)
            MODE_TAIL, MODE_HEAD: begin
                nph    = 2;
                w.head = (pattern_q == MODE_HEAD) ? bright_q : '0;
                if (!phase_q[0]) begin
                    w.tail = dim_q;
                    dur    = DUR_LONG_TAIL;
                end else begin
                    w.tail = bright_q;
                    dur    = DUR_SHORT;
                end
            end
            MODE_FLASH: begin
                nph = 4;
                case (phase_q)
                    2'd0, 2'd2: begin
                        w.head = bright_q;
                        w.tail = dim_q;
                        dur    = DUR_LONG_BOTH;
                    end
                    2'd1: begin
                        w.head = dim_q;
                        w.tail = dim_q;
                        dur    = DUR_SHORT;
                    end
                    default: begin
                        w.head = dim_q;
                        w.tail = bright_q;
                        dur    = DUR_SHORT;
                    end
                endcase
            end
            default: ;
        endcase

        if (dur != 0) begin
            phase_ticks_q++;
            if (phase_ticks_q >= dur) begin
                phase_ticks_q = 0;
                phase_q       = 2'((phase_q + 1) % nph);
            end
        end
        w.anim = mode_q;
        w.avg  = avg_q;
        return w;
    endfunction

    // Offer one input word; bursts of random length with idle gaps between.
    // Returns at the accepting edge with valid still high, so a following
    // word goes out back to back.
    task automatic send_word(logic pv, t_width pw);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!sender_eager && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_pulse_valid <= pv;
        i_pulse_width <= pw;
        do @(posedge i_clk); while (o_in_stall);
        expected_lights.push_back(light_tick(pv, pw));
        words_sent++;
    endtask

    // Stop offering and wait until every owed result word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_lights.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write, then read the register back; the model follows the write.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_SAMPLE_PERIOD) ? 32'h0000_00FF : 32'h0000_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);       // write lands here
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) != (value & mask)) begin
            flag_mismatch($sformatf("register %0d readback: expected %0h, got %0h",
                                    idx, value & mask, prdata & mask));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_THRESHOLD_HIGH: thr_high_q = value[15:0];
            REG_THRESHOLD_LOW:  thr_low_q  = value[15:0];
            REG_SAMPLE_PERIOD:  period_q   = value[7:0];
            REG_DUTY_BRIGHT:    bright_q   = value[15:0];
            REG_DUTY_DIM:       dim_q      = value[15:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Receiver: the stall style is redrawn when its random run ends; a hold-off
    // request pins stall high until its hold counter runs out.
    always @(posedge i_clk) begin
        if (o_in_stall) stalled_cycles++;
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (style_left == 0) begin
                stall_style = stall_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(16, 200);
            end
            style_left--;
            case (stall_style)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 9) < 3);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                default:     i_out_stall <= (style_left % 4 == 0);
            endcase
        end
    end

    // Result check: every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        light_word_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_lights.size() == 0) begin
                flag_mismatch($sformatf("result word with nothing owed (smoothed_width %0d)",
                                        o_smoothed_width));
            end else begin
                want = expected_lights.pop_front();
                if (o_head_duty !== want.head)
                    flag_mismatch($sformatf("word %0d head_duty: expected %0d, got %0d",
                                            words_checked, want.head, o_head_duty));
                if (o_tail_duty !== want.tail)
                    flag_mismatch($sformatf("word %0d tail_duty: expected %0d, got %0d",
                                            words_checked, want.tail, o_tail_duty));
                if (o_animation !== want.anim)
                    flag_mismatch($sformatf("word %0d animation: expected %0d, got %0d",
                                            words_checked, want.anim, o_animation));
                if (o_smoothed_width !== want.avg)
                    flag_mismatch($sformatf("word %0d smoothed_width: expected %0d, got %0d",
                                            words_checked, want.avg, o_smoothed_width));
            end
            words_checked++;
        end
    end

    // Field extremes and a walk through every mode with a step on each tick:
    // rise to tail, fall to head, rise to flash, fall wraps to off with the
    // latch clear, silence gives a zero average and latches off, then a rise.
    task automatic test_directed_sweep();
        write_reg(REG_SAMPLE_PERIOD, 32'd1);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b1, 16'h0000);      // overflow reading
        send_word(1'b0, 16'h5A5A);      // no new pulse, width ignored
        send_word(1'b1, 16'h0001);
        send_word(1'b1, 16'hFFFE);
        repeat (5) send_word(1'b1, 16'd1000);
        repeat (3) send_word(1'b1, 16'hFFFF);
        repeat (5) send_word(1'b1, 16'd500);
        repeat (5) send_word(1'b0, 16'hFFFF);
        send_word(1'b1, 16'h8000);
        send_word(1'b1, 16'h7FFF);
        drain_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills and stalls its input.
    task automatic test_backpressure();
        sender_eager = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) send_word(1'($urandom_range(0, 1)), 16'($urandom));
        sender_eager = 1'b0;
        drain_results();
    endtask

    // Steer into flash mode, then keep the average between the thresholds
    // long enough for the pattern to run all four phases and wrap.
    task automatic test_pattern_phases();
        write_reg(REG_THRESHOLD_HIGH, 32'd1700);
        write_reg(REG_THRESHOLD_LOW, 32'd1300);
        write_reg(REG_SAMPLE_PERIOD, 32'd1);
        write_reg(REG_DUTY_BRIGHT, $urandom_range(0, 16'hFFFF));
        write_reg(REG_DUTY_DIM, $urandom_range(0, 16'hFFFF));
        while (mode_q != MODE_FLASH) begin
            send_word(1'b1, want_rise_q ? 16'd2500 : 16'd600);
        end
        repeat (PATTERN_HOLD) send_word(1'b1, 16'($urandom_range(1450, 1550)));
        drain_results();
    endtask

    // Phases of random traffic, each under fresh register settings. Most
    // segments steer the average across the threshold that is armed; the
    // rest are silence, mid-band levels and raw noise.
    task automatic test_random_traffic();
        int       sent;
        int       phase_no;
        int       phase_end;
        int       seg_left;
        int       roll;
        int       lvl;
        segment_t kind;
        logic     pv;
        t_width   pw;
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_WORDS) begin
            drain_results();
            case (phase_no)
                0: begin
                    // every nonzero average below FFFF crosses, step on every tick
                    write_reg(REG_THRESHOLD_HIGH, 32'd0);
                    write_reg(REG_THRESHOLD_LOW, 32'hFFFF);
                    write_reg(REG_SAMPLE_PERIOD, 32'd0);
                    write_reg(REG_DUTY_BRIGHT, 32'hFFFF);
                    write_reg(REG_DUTY_DIM, 32'd0);
                end
                1: begin
                    // nothing but a zero average can move the mode
                    write_reg(REG_THRESHOLD_HIGH, 32'hFFFF);
                    write_reg(REG_THRESHOLD_LOW, 32'd0);
                    write_reg(REG_SAMPLE_PERIOD, 32'd255);
                    write_reg(REG_DUTY_BRIGHT, 32'd0);
                    write_reg(REG_DUTY_DIM, 32'hFFFF);
                end
                default: begin
                    lvl = $urandom_range(0, 3000);
                    write_reg(REG_THRESHOLD_LOW, lvl);
                    write_reg(REG_THRESHOLD_HIGH, lvl + $urandom_range(0, 3000));
                    write_reg(REG_SAMPLE_PERIOD, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 255) : $urandom_range(0, 6));
                    write_reg(REG_DUTY_BRIGHT, $urandom_range(0, 16'hFFFF));
                    write_reg(REG_DUTY_DIM, $urandom_range(0, 16'hFFFF));
                end
            endcase
            phase_end = sent + PHASE_WORDS;
            while (sent < phase_end && sent < RANDOM_WORDS) begin
                roll = $urandom_range(0, 9);
                kind = (roll < 6) ? SEG_STEER : (roll == 6) ? SEG_SILENT :
                       (roll == 7) ? SEG_MID : SEG_NOISE;
                // a few sample steps' worth of ticks, capped for long periods
                seg_left = ((period_q == 0) ? 1 : int'(period_q)) * $urandom_range(2, 7);
                if (seg_left > 60) seg_left = 60;
                if (kind == SEG_STEER)
                    lvl = want_rise_q ? int'(thr_high_q) + int'($urandom_range(1, 3000))
                                      : int'(thr_low_q) - int'($urandom_range(1, 3000));
                else
                    lvl = (int'(thr_high_q) + int'(thr_low_q)) / 2;
                while (seg_left > 0 && sent < phase_end && sent < RANDOM_WORDS) begin
                    case (kind)
                        SEG_SILENT: begin
                            pv = ($urandom_range(0, 4) == 0);
                            pw = '0;
                        end
                        SEG_NOISE: begin
                            pv = 1'($urandom_range(0, 1));
                            pw = 16'($urandom);
                        end
                        default: begin
                            pv = ($urandom_range(0, 9) < 8);
                            pw = clamp_width(lvl + int'($urandom_range(0, 128)) - 64);
                        end
                    endcase
                    send_word(pv, pw);
                    sent++;
                    seg_left--;
                end
            end
            phase_no++;
        end
        drain_results();
    endtask

    // Main sequence: reset, model reset, tests in turn, then the verdict.
    initial begin
        thr_high_q    = RST_THRESHOLD_HIGH;
        thr_low_q     = RST_THRESHOLD_LOW;
        period_q      = RST_SAMPLE_PERIOD;
        bright_q      = RST_DUTY_BRIGHT;
        dim_q         = RST_DUTY_DIM;
        foreach (ring_q[r]) ring_q[r] = '0;
        slot_q        = 0;
        held_q        = '0;
        held_new_q    = 1'b0;
        step_cnt_q    = '0;
        mode_q        = MODE_OFF;
        pattern_q     = MODE_OFF;
        phase_q       = '0;
        phase_ticks_q = 0;
        off_latch_q   = 1'b0;
        want_rise_q   = 1'b1;
        avg_q         = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_sweep();
        test_backpressure();
        test_pattern_phases();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Run: %0d words sent, %0d checked, %0d sample steps, %0d register writes.",
                 words_sent, words_checked, steps_taken, cfg_writes);
        $display("Modes reached %b, input stalled %0d cycles, %0d mismatches.",
                 modes_seen, stalled_cycles, mismatches);
        if (mismatches == 0 && expected_lights.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d result words still owed.", expected_lights.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
